// ===== hdl/crse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, defaults and helpers for the Catmull-Rom segment evaluator.
// No dependencies; used by every module in hdl/.
package crse_pkg;

	localparam int COORD_WIDTH_DEF     = 32;
	localparam int PARAM_FRAC_BITS_DEF = 16;
	// Guard bits above the coordinate width for doubled coefficients and Horner sums
	localparam int GUARD_BITS          = 6;
	localparam int WINDOW_POINTS       = 4;
	localparam int NUM_AXES            = 3;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	// Coefficient added after each Horner multiply
	typedef enum logic [1:0] {
		COEF_B,
		COEF_C,
		COEF_D
	} coef_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_DRAIN,
		ST_FINAL
	} seq_state_t;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_EVAL = 1'b1
	} req_kind_t;

	// Sequencer commands to the shared multiply-accumulate unit
	typedef struct packed {
		logic       load;
		logic       mul_en;
		axis_t      mul_axis;
		coef_kind_t mul_kind;
	} mac_ctl_t;

	function automatic axis_t next_axis(input axis_t a);
		axis_t n;
		unique case (a)
			AXIS_X:  n = AXIS_Y;
			AXIS_Y:  n = AXIS_Z;
			default: n = AXIS_X;
		endcase
		return n;
	endfunction

	function automatic coef_kind_t next_kind(input coef_kind_t k);
		coef_kind_t n;
		unique case (k)
			COEF_B:  n = COEF_C;
			COEF_C:  n = COEF_D;
			default: n = COEF_B;
		endcase
		return n;
	endfunction

endpackage

// ===== hdl/catmull_rom_segment_eval_top.sv =====
`timescale 1ns / 1ps
// Top level of the Catmull-Rom segment evaluator: request channel, output register.
// Depends on crse_pkg, crse_window, crse_mac and crse_ctrl.
//
// Slave channel (s_*): one request per handshake. tuser[0] picks the kind:
//   0 pushes control point (x, y, z) into a four-point window, 1 evaluates the
//   segment between the second and third points at u (Q1.16, clamped to 1.0).
//   tuser[1] on a push empties the window before the point enters.
// Master channel (m_*): one result per evaluate, none per push. tuser[0] is
//   high once four points are loaded; otherwise the position reads zero.
// Timing: a push leaves the sequencer idle for the next request. An evaluate on a
//   full window runs one coefficient load, nine multiplies through the single shared
//   multiplier (x, y, z interleaved, three Horner steps each), one drain of the
//   product register and one rounding / saturation step that registers the result;
//   the next request is taken once the result is registered. On a window that is
//   not full the evaluate goes straight to the rounding step, which outputs zero.
// Reset: arst_n clears the sequencer, fill count and output valid; window
//   contents are not cleared and play no part until four points are pushed.
// Stall: a result waits in the output register while m_tready is low; the block
//   still takes requests, but a finished evaluate holds until the register frees.
module catmull_rom_segment_eval_top import crse_pkg::*; #(
	parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
	parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF,
	localparam int IN_W  = ((3 * COORD_WIDTH + PARAM_FRAC_BITS + 1 + 7) / 8) * 8,
	localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// coord_x, coord_y, coord_z, param_u, zero padding
	input  logic [IN_W-1:0]  s_tdata,
	// req_type, start_curve
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// pos_x, pos_y, pos_z, zero padding
	output logic [OUT_W-1:0] m_tdata,
	// window_ready
	output logic             m_tuser
);

	localparam int HW = COORD_WIDTH + GUARD_BITS;
	localparam int UW = PARAM_FRAC_BITS + 1;
	localparam logic [UW-1:0] U_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
	localparam logic signed [HW-1:0] SAT_MAX =
		{{(HW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [HW-1:0] SAT_MIN =
		{{(HW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

	logic                                   push;
	logic                                   cap_u;
	logic                                   out_load;
	logic                                   out_zero;
	logic                                   out_free;
	logic                                   window_full;
	mac_ctl_t                               mac_ctl;
	axis_t                                  acc_axis;
	coef_kind_t                             acc_kind;
	logic [NUM_AXES-1:0][HW-1:0]            coef_a;
	logic [HW-1:0]                          coef_acc;
	logic [NUM_AXES-1:0][HW-1:0]            acc;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   point;
	logic [UW-1:0]                          u_in;
	logic [UW-1:0]                          u_q;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   pos;
	logic [NUM_AXES*COORD_WIDTH-1:0]        pos_q;
	logic                                   ready_q;
	logic                                   valid_q;

	// Unpack the request payload
	always_comb begin
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			point[ax] = s_tdata[ax*COORD_WIDTH +: COORD_WIDTH];
		end
		u_in = s_tdata[NUM_AXES*COORD_WIDTH +: UW];
	end

	// Hold u for the whole evaluation, clamped to one
	always_ff @(posedge clk) begin
		if (cap_u) begin
			u_q <= (u_in > U_ONE) ? U_ONE : u_in;
		end
	end

	crse_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_tvalid),
		.req_type    (s_tuser[0]),
		.window_full (window_full),
		.out_free    (out_free),
		.req_ready   (s_tready),
		.push        (push),
		.cap_u       (cap_u),
		.mac_ctl     (mac_ctl),
		.out_load    (out_load),
		.out_zero    (out_zero)
	);

	crse_window #(
		.COORD_WIDTH (COORD_WIDTH),
		.HW          (HW)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.clear    (s_tuser[1]),
		.point    (point),
		.acc_axis (acc_axis),
		.acc_kind (acc_kind),
		.coef_a   (coef_a),
		.coef_acc (coef_acc),
		.full     (window_full)
	);

	crse_mac #(
		.PARAM_FRAC_BITS (PARAM_FRAC_BITS),
		.HW              (HW)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.u        (u_q),
		.coef_a   (coef_a),
		.coef_acc (coef_acc),
		.acc_axis (acc_axis),
		.acc_kind (acc_kind),
		.acc      (acc)
	);

	// Halve the doubled sum with round-half-up, then clip to the coordinate range
	logic signed [HW-1:0] half_v [NUM_AXES];

	always_comb begin
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			half_v[ax] = ($signed(acc[ax]) + $signed(HW'(1))) >>> 1;
			if (out_zero) begin
				pos[ax] = '0;
			end else if (half_v[ax] > SAT_MAX) begin
				pos[ax] = SAT_MAX[COORD_WIDTH-1:0];
			end else if (half_v[ax] < SAT_MIN) begin
				pos[ax] = SAT_MIN[COORD_WIDTH-1:0];
			end else begin
				pos[ax] = half_v[ax][COORD_WIDTH-1:0];
			end
		end
	end

	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_q   <= pos;
			ready_q <= !out_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_W'(pos_q);
	assign m_tuser  = ready_q;

endmodule

// ===== hdl/crse_window.sv =====
`timescale 1ns / 1ps
// Four-point control window per axis, fill counter and coefficient adders.
// Depends on crse_pkg.
module crse_window import crse_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int HW          = COORD_WIDTH_DEF + GUARD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              clear,
	input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] point,
	input  axis_t                             acc_axis,
	input  coef_kind_t                        acc_kind,
	output logic [NUM_AXES-1:0][HW-1:0]       coef_a,
	output logic [HW-1:0]                     coef_acc,
	output logic                              full
);

	logic [WINDOW_POINTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] pt_q;
	logic [2:0] loaded_q;

	// Shift the newest point in at the top, drop the oldest
	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < WINDOW_POINTS - 1; i++) begin
				pt_q[i] <= pt_q[i+1];
			end
			pt_q[WINDOW_POINTS-1] <= point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
		end else if (push) begin
			if (clear) begin
				loaded_q <= 3'd1;
			end else if (loaded_q != 3'(WINDOW_POINTS)) begin
				loaded_q <= loaded_q + 3'd1;
			end
		end
	end

	assign full = (loaded_q == 3'(WINDOW_POINTS));

	logic signed [HW-1:0] p1 [NUM_AXES];
	logic signed [HW-1:0] p2 [NUM_AXES];
	logic signed [HW-1:0] p3 [NUM_AXES];
	logic signed [HW-1:0] p4 [NUM_AXES];
	logic signed [HW-1:0] cb [NUM_AXES];
	logic signed [HW-1:0] cc [NUM_AXES];
	logic signed [HW-1:0] cd [NUM_AXES];

	// Doubled coefficients: a, b, c, d of the uniform half-tension basis
	always_comb begin
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			p1[ax] = HW'($signed(pt_q[0][ax]));
			p2[ax] = HW'($signed(pt_q[1][ax]));
			p3[ax] = HW'($signed(pt_q[2][ax]));
			p4[ax] = HW'($signed(pt_q[3][ax]));
			coef_a[ax] = (p4[ax] - p1[ax]) + ((p2[ax] - p3[ax]) <<< 1) + (p2[ax] - p3[ax]);
			cb[ax] = (p1[ax] <<< 1) - (p2[ax] <<< 2) - p2[ax] + (p3[ax] <<< 2) - p4[ax];
			cc[ax] = p3[ax] - p1[ax];
			cd[ax] = p2[ax] <<< 1;
		end
	end

	logic [1:0] sel;

	always_comb begin
		sel = 2'(acc_axis);
		if (sel > 2'(AXIS_Z)) begin
			sel = 2'(AXIS_Z);
		end
		unique case (acc_kind)
			COEF_B:  coef_acc = cb[sel];
			COEF_C:  coef_acc = cc[sel];
			COEF_D:  coef_acc = cd[sel];
			default: coef_acc = '0;
		endcase
	end

endmodule

// ===== hdl/crse_mac.sv =====
`timescale 1ns / 1ps
// Shared Horner multiply-accumulate unit: one multiplier, product register,
// round-to-nearest and coefficient add into per-axis accumulators. Depends on crse_pkg.
module crse_mac import crse_pkg::*; #(
	parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF,
	parameter int HW              = COORD_WIDTH_DEF + GUARD_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mac_ctl_t                    ctl,
	input  logic [PARAM_FRAC_BITS:0]    u,
	input  logic [NUM_AXES-1:0][HW-1:0] coef_a,
	input  logic [HW-1:0]               coef_acc,
	output axis_t                       acc_axis,
	output coef_kind_t                  acc_kind,
	output logic [NUM_AXES-1:0][HW-1:0] acc
);

	localparam int PW = HW + PARAM_FRAC_BITS + 2;
	localparam logic [PW-1:0] HALF = PW'(1) << (PARAM_FRAC_BITS - 1);

	logic [NUM_AXES-1:0][HW-1:0] h_q;
	logic signed [PW-1:0]        prod_s1;
	logic                        vld_s1;
	axis_t                       axis_s1;
	coef_kind_t                  kind_s1;

	logic signed [HW-1:0] mul_a;
	logic signed [PW-1:0] rsum;
	logic signed [HW-1:0] upd;

	always_comb begin
		mul_a = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			if (ctl.mul_axis == axis_t'(i)) begin
				mul_a = $signed(h_q[i]);
			end
		end
		rsum = prod_s1 + $signed(HALF);
		upd  = $signed(rsum[PARAM_FRAC_BITS +: HW]) + $signed(coef_acc);
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= PW'(mul_a * $signed({1'b0, u}));
		end
		axis_s1 <= ctl.mul_axis;
		kind_s1 <= ctl.mul_kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.mul_en;
		end
	end

	// Load leading coefficients, then fold each rounded product back in
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			h_q <= coef_a;
		end else if (vld_s1) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				if (axis_s1 == axis_t'(i)) begin
					h_q[i] <= upd;
				end
			end
		end
	end

	assign acc_axis = axis_s1;
	assign acc_kind = kind_s1;
	assign acc      = h_q;

endmodule

// ===== hdl/crse_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: accepts requests, steps the shared unit through nine Horner multiplies (axes
// interleaved) on a full window and hands the result to the output stage. Depends on crse_pkg.
module crse_ctrl import crse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_type,
	input  logic     window_full,
	input  logic     out_free,
	output logic     req_ready,
	output logic     push,
	output logic     cap_u,
	output mac_ctl_t mac_ctl,
	output logic     out_load,
	output logic     out_zero
);

	seq_state_t state_q, state_d;
	axis_t      axis_q;
	coef_kind_t kind_q;
	logic       zero_q;
	logic       accept;

	assign accept = req_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_type == REQ_EVAL) begin
					state_d = window_full ? ST_LOAD : ST_FINAL;
				end
			end
			ST_LOAD:  state_d = ST_MUL;
			ST_MUL: begin
				if (axis_q == AXIS_Z && kind_q == COEF_D) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FINAL;
			ST_FINAL: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready        = (state_q == ST_IDLE);
		push             = accept && (req_type == REQ_PUSH);
		cap_u            = accept && (req_type == REQ_EVAL);
		mac_ctl.load     = (state_q == ST_LOAD);
		mac_ctl.mul_en   = (state_q == ST_MUL);
		mac_ctl.mul_axis = axis_q;
		mac_ctl.mul_kind = kind_q;
		out_load         = (state_q == ST_FINAL) && out_free;
		out_zero         = zero_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= AXIS_X;
			kind_q  <= COEF_B;
			zero_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cap_u) begin
				zero_q <= !window_full;
			end
			if (state_q == ST_LOAD) begin
				axis_q <= AXIS_X;
				kind_q <= COEF_B;
			end else if (state_q == ST_MUL) begin
				axis_q <= next_axis(axis_q);
				if (axis_q == AXIS_Z) begin
					kind_q <= next_kind(kind_q);
				end
			end
		end
	end

endmodule

// ===== verif/crse_curve_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Catmull-Rom segment evaluator: watches both stream channels,
// predicts each curve point and compares it with what the block returns.
// Depends on crse_pkg for the request kinds and default widths.
module crse_curve_checker import crse_pkg::*; #(
	parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
	parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF,
	localparam int IN_W  = ((3 * COORD_WIDTH + PARAM_FRAC_BITS + 1 + 7) / 8) * 8,
	localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic [1:0]       s_tuser,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,
	input  logic             m_tuser,
	output int               mismatch_count,
	output int               awaited_count,
	output int               compared_count,
	output int               full_window_count
);

	typedef struct {
		logic [COORD_WIDTH-1:0] x;
		logic [COORD_WIDTH-1:0] y;
		logic [COORD_WIDTH-1:0] z;
		logic                   ready;
	} curve_point_t;

	curve_point_t curve_point_q[$];
	longint       ctrl_pts[WINDOW_POINTS][NUM_AXES];
	int unsigned  pts_loaded = 0;
	int           fails = 0;
	int           awaited = 0;
	int           compared = 0;
	int           full_seen = 0;

	assign mismatch_count    = fails;
	assign awaited_count     = awaited;
	assign compared_count    = compared;
	assign full_window_count = full_seen;

	// Horner evaluation on doubled coefficients, rounded after every multiply
	function automatic logic [COORD_WIDTH-1:0] horner_axis(input longint p1, input longint p2,
			input longint p3, input longint p4, input longint u);
		longint a, b, c, d, h, r, half, maxv, minv;
		a    = -p1 + 3 * p2 - 3 * p3 + p4;
		b    = 2 * p1 - 5 * p2 + 4 * p3 - p4;
		c    = -p1 + p3;
		d    = 2 * p2;
		half = longint'(1) <<< (PARAM_FRAC_BITS - 1);
		maxv = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
		minv = -maxv - 1;
		h = ((a * u + half) >>> PARAM_FRAC_BITS) + b;
		h = ((h * u + half) >>> PARAM_FRAC_BITS) + c;
		h = ((h * u + half) >>> PARAM_FRAC_BITS) + d;
		r = (h + 1) >>> 1;
		if (r > maxv)
			r = maxv;
		if (r < minv)
			r = minv;
		return r[COORD_WIDTH-1:0];
	endfunction

	function automatic curve_point_t predict_point(input logic [PARAM_FRAC_BITS:0] u_raw);
		curve_point_t pt;
		longint u;
		logic [COORD_WIDTH-1:0] axis_val[NUM_AXES];
		u = longint'(u_raw);
		// clamp anything beyond one
		if (u > (longint'(1) <<< PARAM_FRAC_BITS))
			u = longint'(1) <<< PARAM_FRAC_BITS;
		if (pts_loaded < WINDOW_POINTS) begin
			pt.x = '0;
			pt.y = '0;
			pt.z = '0;
			pt.ready = 1'b0;
		end else begin
			for (int a = 0; a < NUM_AXES; a++)
				axis_val[a] = horner_axis(ctrl_pts[0][a], ctrl_pts[1][a],
					ctrl_pts[2][a], ctrl_pts[3][a], u);
			pt.x = axis_val[0];
			pt.y = axis_val[1];
			pt.z = axis_val[2];
			pt.ready = 1'b1;
		end
		return pt;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		curve_point_t want;
		curve_point_t got;
		logic [COORD_WIDTH-1:0] coord;
		if (!arst_n) begin
			pts_loaded = 0;
			curve_point_q.delete();
			awaited = 0;
		end else begin
			// results first: one leaving now was requested at an earlier edge
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[0 +: COORD_WIDTH];
				got.y = m_tdata[COORD_WIDTH +: COORD_WIDTH];
				got.z = m_tdata[2 * COORD_WIDTH +: COORD_WIDTH];
				got.ready = m_tuser;
				if (curve_point_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%t: result with none awaited: x=%h y=%h z=%h ready=%b",
							$realtime, got.x, got.y, got.z, got.ready);
				end else begin
					want = curve_point_q.pop_front();
					compared++;
					if (want.ready)
						full_seen++;
					if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
							got.ready !== want.ready) begin
						fails++;
						if (fails <= 10)
							$display("%t: mismatch: expected x=%h y=%h z=%h ready=%b, got x=%h y=%h z=%h ready=%b",
								$realtime, want.x, want.y, want.z, want.ready,
								got.x, got.y, got.z, got.ready);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (req_kind_t'(s_tuser[0]) == REQ_PUSH) begin
					if (s_tuser[1])
						pts_loaded = 0;
					for (int i = 0; i < WINDOW_POINTS - 1; i++)
						for (int a = 0; a < NUM_AXES; a++)
							ctrl_pts[i][a] = ctrl_pts[i + 1][a];
					for (int a = 0; a < NUM_AXES; a++) begin
						coord = s_tdata[a * COORD_WIDTH +: COORD_WIDTH];
						ctrl_pts[WINDOW_POINTS - 1][a] = longint'($signed(coord));
					end
					if (pts_loaded < WINDOW_POINTS)
						pts_loaded++;
				end else begin
					curve_point_q.insert(curve_point_q.size(),
						predict_point(s_tdata[3 * COORD_WIDTH +: PARAM_FRAC_BITS + 1]));
				end
			end
			awaited = curve_point_q.size();
		end
	end

endmodule

// ===== verif/tb_catmull_rom_segment_eval_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the Catmull-Rom segment evaluator: clock, reset, request and
// result traffic, verdict. Depends on crse_pkg, the block and crse_curve_checker.
module tb_catmull_rom_segment_eval_top;
	import crse_pkg::*;

	localparam int CW   = COORD_WIDTH_DEF;
	localparam int FB   = PARAM_FRAC_BITS_DEF;
	localparam int IN_W  = ((3 * CW + FB + 1 + 7) / 8) * 8;
	localparam int OUT_W = ((3 * CW + 7) / 8) * 8;
	localparam logic [FB:0] U_ONE = (FB + 1)'(1) << FB;
	localparam int RANDOM_ITEMS   = 1350;
	localparam int RX_HOLD_CYCLES = 250;
	// settle time after the last result, longer than a full evaluate
	localparam int SETTLE_CYCLES  = 40;
	localparam int DRAIN_LIMIT    = 5000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic [1:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;

	int fail_total;
	int awaited;
	int compared;
	int full_seen;
	int push_total = 0;
	int eval_total = 0;
	bit tx_gappy = 1'b1;
	bit rx_gappy = 1'b1;
	bit rx_hold  = 1'b0;

	catmull_rom_segment_eval_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	crse_curve_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tuser           (s_tuser),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.m_tuser           (m_tuser),
		.mismatch_count    (fail_total),
		.awaited_count     (awaited),
		.compared_count    (compared),
		.full_window_count (full_seen)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hold reset low from the start, then release it for good
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Give up well beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// Coordinates: mostly full range, with the two extremes and small values mixed in
	function automatic logic [CW-1:0] rand_coord();
		logic [CW-1:0] v;
		case ($urandom_range(0, 7))
			0: v = {1'b0, {(CW - 1){1'b1}}};
			1: v = {1'b1, {(CW - 1){1'b0}}};
			2, 3: begin
				v = $urandom_range(0, 1 << 20);
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// u: zero, exactly one, beyond one (clamped by the block) or anywhere in between
	function automatic logic [FB:0] rand_param();
		logic [FB:0] u;
		case ($urandom_range(0, 9))
			0: u = '0;
			1: u = U_ONE;
			2: u = (FB + 1)'($urandom_range(int'(U_ONE) + 1, (1 << (FB + 1)) - 1));
			default: u = (FB + 1)'($urandom_range(0, int'(U_ONE)));
		endcase
		return u;
	endfunction

	// Offer one request after a random gap and hold it until the block takes it.
	// tvalid is only lowered when a gap follows, so back-to-back requests keep it high.
	task automatic offer_request(input req_kind_t kind, input logic start_flag,
			input logic [CW-1:0] x, input logic [CW-1:0] y, input logic [CW-1:0] z,
			input logic [FB:0] u);
		int gap;
		logic [IN_W-1:0] word;
		gap = tx_gappy ? $urandom_range(0, 10) : 0;
		word = '0;
		word[0 +: CW]      = x;
		word[CW +: CW]     = y;
		word[2 * CW +: CW] = z;
		word[3 * CW +: FB + 1] = u;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= {start_flag, kind};
		do @(posedge clk); while (!s_tready);
		if (kind == REQ_PUSH)
			push_total++;
		else
			eval_total++;
	endtask

	// Push a random point; the u field is noise here and still gets random bits
	task automatic push_point(input logic start_flag);
		offer_request(REQ_PUSH, start_flag, rand_coord(), rand_coord(), rand_coord(),
			logic'($urandom) ? rand_param() : (FB + 1)'($urandom));
	endtask

	// Evaluate; the coordinate fields are ignored by the block, so fill them with noise
	task automatic eval_at(input logic start_flag, input logic [FB:0] u);
		offer_request(REQ_EVAL, start_flag, $urandom, $urandom, $urandom, u);
	endtask

	// Result side: a random stall before each result, long hold on request
	initial begin
		int stall;
		int taken;
		taken = 0;
		wait (arst_n);
		forever begin
			if (rx_hold) begin
				// starve the block so that it fills up and stalls its request side
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
			if (taken % 50 == 0)
				rx_gappy = ($urandom_range(0, 2) != 0);
			stall = rx_gappy ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	// Request side and verdict
	initial begin
		int seq_kind;
		int n;
		int limit;
		bit hold_done;
		bit drain_done;
		hold_done  = 1'b0;
		drain_done = 1'b0;
		wait (arst_n);
		@(posedge clk);

		// Directed part
		// evaluate on an empty window, start flag set: not ready, flag ignored
		eval_at(1'b1, '0);
		// alternate the extremes so that the segment overshoots and saturates
		offer_request(REQ_PUSH, 1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, '0);
		offer_request(REQ_PUSH, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, '1);
		offer_request(REQ_PUSH, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, '0);
		// only three points so far
		eval_at(1'b0, U_ONE);
		offer_request(REQ_PUSH, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, '0);
		eval_at(1'b0, '0);
		eval_at(1'b0, U_ONE);
		// every bit of u set: beyond one, clamped
		eval_at(1'b0, '1);
		eval_at(1'b0, U_ONE >> 1);
		eval_at(1'b0, (FB + 1)'(1));
		eval_at(1'b0, U_ONE - 1'b1);
		// slide the window by one point
		offer_request(REQ_PUSH, 1'b0, 32'h1234_5678, 32'hedcb_a988, 32'h0000_8000, '0);
		eval_at(1'b0, rand_param());
		// restart the curve: a single point is not enough
		offer_request(REQ_PUSH, 1'b1, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, '0);
		eval_at(1'b0, U_ONE >> 2);
		offer_request(REQ_PUSH, 1'b0, 32'h0003_0000, 32'hffff_8000, 32'h0000_4000, '0);
		offer_request(REQ_PUSH, 1'b0, 32'hfffe_0000, 32'h0005_0000, 32'h0007_0000, '0);
		offer_request(REQ_PUSH, 1'b0, 32'h0000_0000, 32'h0001_8000, 32'hfff0_0000, '0);
		eval_at(1'b0, U_ONE >> 2);
		// start flag on an evaluate leaves the window alone
		eval_at(1'b1, (U_ONE >> 1) + (U_ONE >> 2));
		offer_request(REQ_PUSH, 1'b0, '0, '0, '0, '0);
		eval_at(1'b0, U_ONE);

		// Random part: mostly whole curves with random content, some noise
		while (push_total + eval_total < 23 + RANDOM_ITEMS) begin
			tx_gappy = ($urandom_range(0, 3) != 0);
			if (!hold_done && push_total + eval_total > 500) begin
				// long receiver hold while requests keep coming back-to-back
				hold_done = 1'b1;
				tx_gappy  = 1'b0;
				rx_hold   = 1'b1;
				push_point(1'b1);
				repeat (3) push_point(1'b0);
				repeat (16) eval_at(1'b0, rand_param());
			end
			if (!drain_done && push_total + eval_total > 900) begin
				// pause until every awaited result is back
				drain_done = 1'b1;
				s_tvalid <= 1'b0;
				wait (awaited == 0);
			end
			seq_kind = $urandom_range(0, 9);
			if (seq_kind <= 6) begin
				push_point(1'b1);
				repeat (3) push_point(1'b0);
				n = $urandom_range(1, 8);
				repeat (n) begin
					if ($urandom_range(0, 9) < 7)
						eval_at($urandom_range(0, 9) == 0, rand_param());
					else
						push_point($urandom_range(0, 19) == 0);
				end
			end else if (seq_kind == 7) begin
				n = $urandom_range(1, 6);
				repeat (n)
					offer_request(req_kind_t'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)),
						rand_coord(), rand_coord(), rand_coord(), (FB + 1)'($urandom));
			end else if (seq_kind == 8) begin
				// broken curve: too few points before the evaluate
				push_point(1'b1);
				n = $urandom_range(0, 2);
				repeat (n) push_point(1'b0);
				eval_at(1'($urandom_range(0, 1)), rand_param());
			end else begin
				eval_at(1'b1, rand_param());
				push_point(1'b0);
			end
		end
		s_tvalid <= 1'b0;

		// Drain, with a limit, then let the block settle
		limit = 0;
		while (awaited != 0 && limit < DRAIN_LIMIT) begin
			@(posedge clk);
			limit++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run drove %0d point pushes and %0d evaluate requests.", push_total, eval_total);
		$display("Compared %0d curve points, %0d of them on a full window; %0d still awaited.",
			compared, full_seen, awaited);
		if (fail_total == 0 && awaited == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
